### design/fpmd_pkg.sv
`default_nettype none
package fpmd_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int SUM_BITS_DEF   = 24;

	localparam int MAG_BITS      = 16;
	localparam int STEP_BITS     = 10;
	localparam int LEVEL_BITS    = 16;
	localparam int THR_BITS      = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEP_X     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEP_Y     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STILL_X        = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_STILL_Y        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MOTION_CEILING = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MOTION_FLOOR   = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRESS_THRESH   = 3'd6;

	localparam logic [STEP_BITS-1:0]  RST_MAX_STEP = 10'd50;
	localparam logic [STEP_BITS-1:0]  RST_STILL    = 10'd2;
	localparam logic [LEVEL_BITS-1:0] RST_CEILING  = 16'd3200;
	localparam logic [LEVEL_BITS-1:0] RST_FLOOR    = 16'd560;
	localparam logic [THR_BITS-1:0]   RST_PRESS    = 24'd1600;

	typedef struct packed {
		logic [STEP_BITS-1:0]  max_step_x;
		logic [STEP_BITS-1:0]  max_step_y;
		logic [STEP_BITS-1:0]  still_x;
		logic [STEP_BITS-1:0]  still_y;
		logic [LEVEL_BITS-1:0] motion_ceiling;
		logic [LEVEL_BITS-1:0] motion_floor;
		logic [THR_BITS-1:0]   press_threshold;
	} cfg_t;

	typedef struct packed {
		logic                done;
		logic [MAG_BITS-1:0] value;
	} mag_rsp_t;

endpackage
`default_nettype wire

### design/fpmd_cfg_regs.sv
`default_nettype none
module fpmd_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fpmd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [fpmd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output fpmd_pkg::cfg_t                          cfg
);

	fpmd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_step_x      <= fpmd_pkg::RST_MAX_STEP;
			cfg_q.max_step_y      <= fpmd_pkg::RST_MAX_STEP;
			cfg_q.still_x         <= fpmd_pkg::RST_STILL;
			cfg_q.still_y         <= fpmd_pkg::RST_STILL;
			cfg_q.motion_ceiling  <= fpmd_pkg::RST_CEILING;
			cfg_q.motion_floor    <= fpmd_pkg::RST_FLOOR;
			cfg_q.press_threshold <= fpmd_pkg::RST_PRESS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpmd_pkg::REG_MAX_STEP_X: begin
					cfg_q.max_step_x <= cfg_data[fpmd_pkg::STEP_BITS-1:0];
				end
				fpmd_pkg::REG_MAX_STEP_Y: begin
					cfg_q.max_step_y <= cfg_data[fpmd_pkg::STEP_BITS-1:0];
				end
				fpmd_pkg::REG_STILL_X: begin
					cfg_q.still_x <= cfg_data[fpmd_pkg::STEP_BITS-1:0];
				end
				fpmd_pkg::REG_STILL_Y: begin
					cfg_q.still_y <= cfg_data[fpmd_pkg::STEP_BITS-1:0];
				end
				fpmd_pkg::REG_MOTION_CEILING: begin
					cfg_q.motion_ceiling <= cfg_data[fpmd_pkg::LEVEL_BITS-1:0];
				end
				fpmd_pkg::REG_MOTION_FLOOR: begin
					cfg_q.motion_floor <= cfg_data[fpmd_pkg::LEVEL_BITS-1:0];
				end
				fpmd_pkg::REG_PRESS_THRESH: begin
					cfg_q.press_threshold <= cfg_data[fpmd_pkg::THR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

### design/fpmd_mag_unit.sv
`default_nettype none
module fpmd_mag_unit #(
	parameter int COORD_BITS = fpmd_pkg::COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COORD_BITS-1:0] dx,
	input  wire logic [COORD_BITS-1:0] dy,
	output fpmd_pkg::mag_rsp_t         rsp
);

	localparam int MW   = fpmd_pkg::MAG_BITS;
	localparam int PW   = 2 * MW;
	localparam int NW   = 2 * COORD_BITS + 16;
	localparam int FW   = PW + 3;
	localparam int CW   = (NW > FW) ? NW : FW;
	localparam int IDXW = $clog2(MW);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_SQX  = 3'd1;
	localparam logic [2:0] M_SQY  = 3'd2;
	localparam logic [2:0] M_SUM  = 3'd3;
	localparam logic [2:0] M_TRY  = 3'd4;
	localparam logic [2:0] M_CMP  = 3'd5;
	localparam logic [2:0] M_DONE = 3'd6;

	logic [2:0]      state_q;
	logic [MW-1:0]   dx_q;
	logic [MW-1:0]   dy_q;
	logic [PW-1:0]   prod_q;
	logic [PW-1:0]   dxsq_q;
	logic [CW-1:0]   n_q;
	logic [MW-1:0]   root_q;
	logic [IDXW-1:0] idx_q;

	logic [MW-1:0] mul_a;
	logic [PW-1:0] mul_c;
	logic [MW-1:0] trial;
	logic [CW-1:0] n_c;
	logic [CW-1:0] five_sq;

	assign trial = root_q | (MW'(1) << idx_q);

	// One shared multiplier squares dx, dy and then every trial root.
	always_comb begin
		case (state_q)
			M_SQX:   mul_a = dx_q;
			M_SQY:   mul_a = dy_q;
			default: mul_a = trial;
		endcase
	end

	assign mul_c   = mul_a * mul_a;
	assign n_c     = (CW'(dxsq_q) + (CW'(prod_q) << 6) + (CW'(prod_q) << 5)
	                 + (CW'(prod_q) << 2)) << 8;
	assign five_sq = (CW'(prod_q) << 2) + CW'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
		end else begin
			unique case (state_q)
				M_IDLE:  if (start) state_q <= M_SQX;
				M_SQX:   state_q <= M_SQY;
				M_SQY:   state_q <= M_SUM;
				M_SUM:   state_q <= M_TRY;
				M_TRY:   state_q <= M_CMP;
				M_CMP:   state_q <= (idx_q == '0) ? M_DONE : M_TRY;
				M_DONE:  state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// The root is the largest 16 bit r with 5*r*r <= (dx^2 + 100*dy^2) * 256.
	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			dx_q <= MW'(dx);
			dy_q <= MW'(dy);
		end
		if (state_q == M_SQX || state_q == M_SQY || state_q == M_TRY) begin
			prod_q <= mul_c;
		end
		if (state_q == M_SQY) begin
			dxsq_q <= prod_q;
		end
		if (state_q == M_SUM) begin
			n_q    <= n_c;
			root_q <= '0;
			idx_q  <= IDXW'(MW - 1);
		end
		if (state_q == M_CMP) begin
			if (five_sq <= n_q) begin
				root_q <= trial;
			end
			if (idx_q != '0) begin
				idx_q <= idx_q - IDXW'(1);
			end
		end
	end

	assign rsp.done  = (state_q == M_DONE);
	assign rsp.value = root_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("magnitude done held for more than one cycle");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (((CW + 3)'(root_q) * (CW + 3)'(root_q) * 5) <= (CW + 3)'(n_q)))
		else $error("magnitude root exceeds its bound");

	a_cmp_after_try: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == M_CMP) |-> ($past(state_q) == M_TRY))
		else $error("compare step without a preceding trial square");

endmodule
`default_nettype wire

### design/fingertip_press_motion_detector_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | finger_present, tip_x, tip_y
// out     | output    | out_valid / out_ready| step_valid, moving_down, motion_value,
//         |           |                      | motion_sum, motion_qualifies, press_detected
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A moving finger's request is evaluated, dx and dy are squared and the radicand formed,
// each of the 16 result bits of the square root is tried and compared on one shared 16 by
// 16 multiplier, and then the root is finished, collected and loaded into the output
// register before the next request is taken. Absent, first or still requests skip the
// square root and go from evaluation straight to the result stage.
// Reset restores the register defaults and forgets the previous point and the sum.
// A new request is taken once the previous one has been placed in the output register;
// a stalled output holds the next finished result until it is taken.
`default_nettype none
module fingertip_press_motion_detector_unit #(
	parameter int COORD_BITS = fpmd_pkg::COORD_BITS_DEF,
	parameter int SUM_BITS   = fpmd_pkg::SUM_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fpmd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [fpmd_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               finger_present,
	input  wire logic [COORD_BITS-1:0]              tip_x,
	input  wire logic [COORD_BITS-1:0]              tip_y,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    step_valid,
	output logic                                    moving_down,
	output logic [fpmd_pkg::MAG_BITS-1:0]           motion_value,
	output logic [SUM_BITS-1:0]                     motion_sum,
	output logic                                    motion_qualifies,
	output logic                                    press_detected
);

	localparam int MW  = fpmd_pkg::MAG_BITS;
	localparam int SW  = fpmd_pkg::STEP_BITS;
	localparam int DW  = (COORD_BITS > SW) ? COORD_BITS : SW;
	localparam int TW  = (SUM_BITS > fpmd_pkg::THR_BITS) ? SUM_BITS : fpmd_pkg::THR_BITS;
	localparam int SB1 = SUM_BITS + 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EVAL   = 2'd1;
	localparam logic [1:0] S_WAIT   = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	localparam logic [1:0] K_CLEAR = 2'd0;
	localparam logic [1:0] K_FIRST = 2'd1;
	localparam logic [1:0] K_STILL = 2'd2;
	localparam logic [1:0] K_MOVE  = 2'd3;

	fpmd_pkg::cfg_t     cfg;
	fpmd_pkg::mag_rsp_t mag_rsp;

	logic [1:0]            state_q;
	logic                  present_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic                  last_seen_q;
	logic [SUM_BITS-1:0]   run_sum_q;
	logic [1:0]            kind_q;
	logic                  valid_q;
	logic                  down_q;
	logic [MW-1:0]         mag_q;

	logic                  out_valid_q;
	logic                  step_valid_q;
	logic                  moving_down_q;
	logic [MW-1:0]         motion_value_q;
	logic [SUM_BITS-1:0]   motion_sum_q;
	logic                  motion_qualifies_q;
	logic                  press_detected_q;

	logic [COORD_BITS-1:0] dx_c;
	logic [COORD_BITS-1:0] dy_c;
	logic                  valid_c;
	logic                  still_c;
	logic [1:0]            kind_c;
	logic                  mag_start;
	logic                  load_out;

	logic [MW-1:0]         motion_c;
	logic                  qual_c;
	logic [SB1-1:0]        sum_wide;
	logic [SUM_BITS-1:0]   sum_c;
	logic                  press_c;
	logic                  r_valid;
	logic                  r_down;
	logic [MW-1:0]         r_motion;
	logic [SUM_BITS-1:0]   r_sum;
	logic                  r_qual;
	logic                  r_press;

	fpmd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fpmd_mag_unit #(
		.COORD_BITS (COORD_BITS)
	) u_mag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mag_start),
		.dx     (dx_c),
		.dy     (dy_c),
		.rsp    (mag_rsp)
	);

	assign in_ready = (state_q == S_IDLE);

	assign dx_c    = (x_q > last_x_q) ? (x_q - last_x_q) : (last_x_q - x_q);
	assign dy_c    = (y_q > last_y_q) ? (y_q - last_y_q) : (last_y_q - y_q);
	assign valid_c = (DW'(dx_c) < DW'(cfg.max_step_x)) && (DW'(dy_c) < DW'(cfg.max_step_y));
	assign still_c = (DW'(dx_c) < DW'(cfg.still_x)) && (DW'(dy_c) < DW'(cfg.still_y));

	always_comb begin
		if (!present_q) begin
			kind_c = K_CLEAR;
		end else if (!last_seen_q) begin
			kind_c = K_FIRST;
		end else if (still_c) begin
			kind_c = K_STILL;
		end else begin
			kind_c = K_MOVE;
		end
	end

	assign mag_start = (state_q == S_EVAL) && (kind_c == K_MOVE);
	assign load_out  = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	assign motion_c = (mag_q > cfg.motion_ceiling) ? '0 : mag_q;
	assign qual_c   = down_q && (motion_c > cfg.motion_floor) && valid_q;
	assign sum_wide = SB1'(run_sum_q) + SB1'(motion_c);
	always_comb begin
		if (!qual_c) begin
			sum_c = '0;
		end else if (sum_wide[SUM_BITS]) begin
			sum_c = '1;
		end else begin
			sum_c = sum_wide[SUM_BITS-1:0];
		end
	end
	assign press_c = down_q && (TW'(sum_c) > TW'(cfg.press_threshold));

	always_comb begin
		r_valid  = 1'b0;
		r_down   = 1'b0;
		r_motion = '0;
		r_sum    = '0;
		r_qual   = 1'b0;
		r_press  = 1'b0;
		case (kind_q)
			K_STILL: begin
				r_valid = valid_q;
			end
			K_MOVE: begin
				r_valid  = valid_q;
				r_down   = down_q;
				r_motion = motion_c;
				r_sum    = sum_c;
				r_qual   = qual_c;
				r_press  = press_c;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_seen_q <= 1'b0;
			run_sum_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= (kind_c == K_MOVE) ? S_WAIT : S_RESULT;
				end
				S_WAIT: begin
					if (mag_rsp.done) state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
				run_sum_q   <= r_sum;
				if (kind_q == K_CLEAR) begin
					last_seen_q <= 1'b0;
				end else begin
					last_seen_q <= 1'b1;
					last_x_q    <= x_q;
					last_y_q    <= y_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			present_q <= finger_present;
			x_q       <= tip_x;
			y_q       <= tip_y;
		end
		if (state_q == S_EVAL) begin
			kind_q  <= kind_c;
			valid_q <= valid_c;
			down_q  <= (y_q > last_y_q);
			mag_q   <= '0;
		end
		if (state_q == S_WAIT && mag_rsp.done) begin
			mag_q <= mag_rsp.value;
		end
		if (load_out) begin
			step_valid_q       <= r_valid;
			moving_down_q      <= r_down;
			motion_value_q     <= r_motion;
			motion_sum_q       <= r_sum;
			motion_qualifies_q <= r_qual;
			press_detected_q   <= r_press;
		end
	end

	assign out_valid        = out_valid_q;
	assign step_valid       = step_valid_q;
	assign moving_down      = moving_down_q;
	assign motion_value     = motion_value_q;
	assign motion_sum       = motion_sum_q;
	assign motion_qualifies = motion_qualifies_q;
	assign press_detected   = press_detected_q;

endmodule
`default_nettype wire

### tb/fingertip_press_motion_detector_unit_tb.sv
`default_nettype none
module fingertip_press_motion_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpmd_pkg::*;

	localparam int COORD_W = COORD_BITS_DEF;
	localparam int SUM_W = SUM_BITS_DEF;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};
	localparam logic [MAG_BITS-1:0] MAG_TOP = {MAG_BITS{1'b1}};
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic                step_valid;
		logic                moving_down;
		logic [MAG_BITS-1:0] motion_value;
		logic [SUM_W-1:0]    motion_sum;
		logic                motion_qualifies;
		logic                press_detected;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic finger_present = 1'b0;
	logic [COORD_W-1:0] tip_x = '0;
	logic [COORD_W-1:0] tip_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic step_valid;
	logic moving_down;
	logic [MAG_BITS-1:0] motion_value;
	logic [SUM_W-1:0] motion_sum;
	logic motion_qualifies;
	logic press_detected;

	cfg_t settings;
	logic [COORD_W-1:0] prev_x;
	logic [COORD_W-1:0] prev_y;
	logic prev_seen;
	logic [SUM_W-1:0] acc_sum;

	frame_result_t pending_results[$];
	frame_result_t oldest;
	int send_idle = 0;
	int recv_idle = 0;
	int error_count = 0;
	int cycle_count = 0;

	fingertip_press_motion_detector_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.finger_present(finger_present),
		.tip_x(tip_x),
		.tip_y(tip_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.step_valid(step_valid),
		.moving_down(moving_down),
		.motion_value(motion_value),
		.motion_sum(motion_sum),
		.motion_qualifies(motion_qualifies),
		.press_detected(press_detected)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** fingertip_press_motion_detector_unit: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] radicand);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 24; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root;
	endfunction

	function automatic frame_result_t predict_frame(logic present, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y);
		frame_result_t res;
		logic [63:0] dx;
		logic [63:0] dy;
		logic [63:0] mag;
		logic [SUM_W:0] total;
		res = '0;
		if (!present) begin
			prev_seen = 1'b0;
			acc_sum = '0;
			return res;
		end
		if (!prev_seen) begin
			prev_x = x;
			prev_y = y;
			prev_seen = 1'b1;
			acc_sum = '0;
			return res;
		end
		dx = (x > prev_x) ? 64'(x - prev_x) : 64'(prev_x - x);
		dy = (y > prev_y) ? 64'(y - prev_y) : 64'(prev_y - y);
		res.step_valid = (dx < settings.max_step_x) && (dy < settings.max_step_y);
		if (!((dx < settings.still_x) && (dy < settings.still_y))) begin
			mag = int_sqrt((dx * dx + 64'd100 * dy * dy) * 64'd256 / 64'd5);
			if (mag > MAG_TOP)
				mag = MAG_TOP;
			if (mag > settings.motion_ceiling)
				mag = '0;
			res.moving_down = (y > prev_y);
			res.motion_value = mag[MAG_BITS-1:0];
			res.motion_qualifies = res.moving_down && (mag > settings.motion_floor)
				&& res.step_valid;
			if (res.motion_qualifies) begin
				total = acc_sum + mag[MAG_BITS-1:0];
				res.motion_sum = (total > SUM_TOP) ? SUM_TOP : total[SUM_W-1:0];
			end
			res.press_detected = res.moving_down && (res.motion_sum > settings.press_threshold);
		end
		prev_x = x;
		prev_y = y;
		acc_sum = res.motion_sum;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("motion result arrived with no request outstanding");
				error_count++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("step_valid", oldest.step_valid, step_valid);
				check_field("moving_down", oldest.moving_down, moving_down);
				check_field("motion_value", oldest.motion_value, motion_value);
				check_field("motion_sum", oldest.motion_sum, motion_sum);
				check_field("motion_qualifies", oldest.motion_qualifies, motion_qualifies);
				check_field("press_detected", oldest.press_detected, press_detected);
			end
		end
	end

	task automatic send_frame(input logic present, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		finger_present <= present;
		tip_x <= x;
		tip_y <= y;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_frame(present, x, y));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		logic [CFG_DATA_BITS-1:0] data;
		data = CFG_DATA_BITS'($urandom());
		case (idx)
			REG_MAX_STEP_X: begin
				data[STEP_BITS-1:0] = value[STEP_BITS-1:0];
				settings.max_step_x = value[STEP_BITS-1:0];
			end
			REG_MAX_STEP_Y: begin
				data[STEP_BITS-1:0] = value[STEP_BITS-1:0];
				settings.max_step_y = value[STEP_BITS-1:0];
			end
			REG_STILL_X: begin
				data[STEP_BITS-1:0] = value[STEP_BITS-1:0];
				settings.still_x = value[STEP_BITS-1:0];
			end
			REG_STILL_Y: begin
				data[STEP_BITS-1:0] = value[STEP_BITS-1:0];
				settings.still_y = value[STEP_BITS-1:0];
			end
			REG_MOTION_CEILING: begin
				data[LEVEL_BITS-1:0] = value[LEVEL_BITS-1:0];
				settings.motion_ceiling = value[LEVEL_BITS-1:0];
			end
			REG_MOTION_FLOOR: begin
				data[LEVEL_BITS-1:0] = value[LEVEL_BITS-1:0];
				settings.motion_floor = value[LEVEL_BITS-1:0];
			end
			REG_PRESS_THRESH: begin
				data = value;
				settings.press_threshold = value[THR_BITS-1:0];
			end
			default: ;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_settings(input cfg_t s);
		write_reg(REG_MAX_STEP_X, CFG_DATA_BITS'(s.max_step_x));
		write_reg(REG_MAX_STEP_Y, CFG_DATA_BITS'(s.max_step_y));
		write_reg(REG_STILL_X, CFG_DATA_BITS'(s.still_x));
		write_reg(REG_STILL_Y, CFG_DATA_BITS'(s.still_y));
		write_reg(REG_MOTION_CEILING, CFG_DATA_BITS'(s.motion_ceiling));
		write_reg(REG_MOTION_FLOOR, CFG_DATA_BITS'(s.motion_floor));
		write_reg(REG_PRESS_THRESH, CFG_DATA_BITS'(s.press_threshold));
		write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom()));
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t random_settings();
		cfg_t s;
		case ($urandom_range(0, 3))
			0: begin
				s.max_step_x = RST_MAX_STEP;
				s.max_step_y = RST_MAX_STEP;
				s.still_x = RST_STILL;
				s.still_y = RST_STILL;
				s.motion_ceiling = RST_CEILING;
				s.motion_floor = LEVEL_BITS'($urandom_range(0, 1200));
				s.press_threshold = THR_BITS'($urandom_range(0, 4000));
			end
			1: begin
				s.max_step_x = '1;
				s.max_step_y = '1;
				s.still_x = STEP_BITS'($urandom_range(0, 2));
				s.still_y = STEP_BITS'($urandom_range(0, 2));
				s.motion_ceiling = '1;
				s.motion_floor = LEVEL_BITS'($urandom_range(0, 800));
				s.press_threshold = THR_BITS'($urandom_range(0, 2_000_000));
			end
			2: begin
				s.max_step_x = STEP_BITS'($urandom());
				s.max_step_y = STEP_BITS'($urandom());
				s.still_x = STEP_BITS'($urandom());
				s.still_y = STEP_BITS'($urandom());
				s.motion_ceiling = LEVEL_BITS'($urandom());
				s.motion_floor = LEVEL_BITS'($urandom());
				s.press_threshold = THR_BITS'($urandom());
			end
			default: begin
				s.max_step_x = STEP_BITS'($urandom_range(10, 200));
				s.max_step_y = STEP_BITS'($urandom_range(10, 200));
				s.still_x = STEP_BITS'($urandom_range(0, 10));
				s.still_y = STEP_BITS'($urandom_range(0, 10));
				s.motion_ceiling = LEVEL_BITS'($urandom_range(500, 20000));
				s.motion_floor = LEVEL_BITS'($urandom_range(0, 2000));
				s.press_threshold = THR_BITS'($urandom_range(0, 20000));
			end
		endcase
		return s;
	endfunction

	// Runs with the reset register values: a downward stroke builds up to a press, then
	// still, upward, sideways, out-of-range and over-ceiling moves, and lost fingers.
	task automatic test_directed_frames();
		send_frame(1'b0, 10'd1023, 10'd1023);
		send_frame(1'b1, 10'd0, 10'd0);
		send_frame(1'b1, 10'd1, 10'd1);
		send_frame(1'b1, 10'd1, 10'd11);
		send_frame(1'b1, 10'd1, 10'd21);
		send_frame(1'b1, 10'd1, 10'd31);
		send_frame(1'b1, 10'd1, 10'd31);
		send_frame(1'b1, 10'd3, 10'd31);
		send_frame(1'b1, 10'd3, 10'd21);
		send_frame(1'b1, 10'd43, 10'd21);
		send_frame(1'b1, 10'd500, 10'd100);
		send_frame(1'b1, 10'd500, 10'd145);
		send_frame(1'b1, 10'd549, 10'd194);
		send_frame(1'b1, 10'd1023, 10'd1023);
		send_frame(1'b0, 10'd0, 10'd0);
		send_frame(1'b1, 10'd1023, 10'd1023);
		send_frame(1'b1, 10'd1023, 10'd1022);
		send_frame(1'b1, 10'd0, 10'd0);
		wait_all_results();
	endtask

	task automatic corner_stroke();
		send_frame(1'b0, 10'd512, 10'd512);
		send_frame(1'b1, 10'd0, 10'd0);
		send_frame(1'b1, 10'd0, 10'd1023);
		send_frame(1'b1, 10'd1023, 10'd0);
		send_frame(1'b1, 10'd1023, 10'd1);
		send_frame(1'b1, 10'd0, 10'd3);
		wait_all_results();
	endtask

	task automatic test_register_extremes();
		cfg_t s;
		s = '0;
		apply_settings(s);
		corner_stroke();
		s.max_step_x = '1;
		s.max_step_y = '1;
		s.still_x = '1;
		s.still_y = '1;
		s.motion_ceiling = '1;
		s.motion_floor = '1;
		s.press_threshold = '1;
		apply_settings(s);
		corner_stroke();
		s.still_x = '0;
		s.still_y = '0;
		s.motion_floor = '0;
		s.press_threshold = '0;
		apply_settings(s);
		corner_stroke();
	endtask

	// Mostly finger strokes with random content: slow downward drift with jitter, or wide
	// zig-zag sweeps that pile up a large sum. The rest is noise, jumps and lost fingers.
	task automatic test_random_frames(input int count);
		int sent;
		int next_reconfig;
		int kind;
		int len;
		int x;
		int y;
		sent = 0;
		next_reconfig = 0;
		while (sent < count) begin
			if (sent >= next_reconfig) begin
				wait_all_results();
				apply_settings(random_settings());
				next_reconfig += 100;
			end
			kind = $urandom_range(0, 9);
			len = $urandom_range(3, 60);
			x = $urandom_range(0, 1023);
			y = $urandom_range(0, 400);
			for (int i = 0; i < len && sent < count; i++) begin
				if (kind == 0) begin
					send_frame(1'($urandom()), 10'($urandom()), 10'($urandom()));
				end else if (kind <= 2) begin
					x = (i % 2 == 1) ? 1023 - $urandom_range(0, 3) : $urandom_range(0, 3);
					y += $urandom_range(1, 6);
					if (y > 1023)
						y = 1023;
					send_frame(1'b1, 10'(x), 10'(y));
				end else if ($urandom_range(0, 29) == 0) begin
					send_frame(1'b0, 10'($urandom()), 10'($urandom()));
				end else begin
					if ($urandom_range(0, 19) == 0) begin
						x = $urandom_range(0, 1023);
						y = $urandom_range(0, 1023);
					end else begin
						x += $urandom_range(0, 20) - 10;
						y += $urandom_range(0, 16) - 3;
					end
					x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
					y = (y < 0) ? 0 : (y > 1023) ? 1023 : y;
					send_frame(1'b1, 10'(x), 10'(y));
				end
				sent++;
			end
		end
		wait_all_results();
	endtask

	initial begin
		settings.max_step_x = RST_MAX_STEP;
		settings.max_step_y = RST_MAX_STEP;
		settings.still_x = RST_STILL;
		settings.still_y = RST_STILL;
		settings.motion_ceiling = RST_CEILING;
		settings.motion_floor = RST_FLOOR;
		settings.press_threshold = RST_PRESS;
		prev_x = '0;
		prev_y = '0;
		prev_seen = 1'b0;
		acc_sum = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 34;
		recv_idle = 74;
		test_directed_frames();
		test_register_extremes();
		test_random_frames(400);

		send_idle = 74;
		recv_idle = 34;
		test_random_frames(400);

		send_idle = 0;
		recv_idle = 0;
		test_random_frames(400);

		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("** fingertip_press_motion_detector_unit: PASSED **");
		else
			$display("** fingertip_press_motion_detector_unit: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
design/fpmd_pkg.sv
design/fpmd_cfg_regs.sv
design/fpmd_mag_unit.sv
design/fingertip_press_motion_detector_unit.sv
tb/fingertip_press_motion_detector_unit_tb.sv
